FILE: rtl/ilfd_pkg.sv
// ----------------------------------------------------------------------------
// ilfd_pkg
// Shared types and constants of the inductive line follow PWM drive.
// ----------------------------------------------------------------------------
`default_nettype none

package ilfd_pkg;

    // duty and register widths
    localparam int DUTY_W   = 7;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;
    localparam int CODE_W   = 10;
    localparam int STEP_W   = $clog2(DUTY_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PWM_TOP    = 2'd2;

    // register reset values
    localparam logic [1:0]        TRACK_MODE_RST = 2'd0;
    localparam logic [DUTY_W-1:0] FULL_SCALE_RST = 7'd75;
    localparam logic [DUTY_W-1:0] PWM_TOP_RST    = 7'd100;

    // track modes
    localparam logic [1:0] MODE_FWD_FRONT  = 2'd0;
    localparam logic [1:0] MODE_BACK_REAR  = 2'd1;
    localparam logic [1:0] MODE_FWD_REAR   = 2'd2;
    localparam logic [1:0] MODE_BACK_FRONT = 2'd3;

    // opcodes
    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    // duty code of a channel that is always off (-1)
    localparam logic [DUTY_W:0] DUTY_OFF = 8'hFF;

    typedef struct packed {
        logic              opcode;
        logic [CODE_W-1:0] front_left;
        logic [CODE_W-1:0] front_right;
        logic [CODE_W-1:0] rear_left;
        logic [CODE_W-1:0] rear_right;
    } in_beat_t;

    typedef struct packed {
        logic left_a_pin;
        logic left_b_pin;
        logic right_a_pin;
        logic right_b_pin;
    } out_beat_t;

    // result of the share unit
    typedef struct packed {
        logic              done;
        logic              zero;
        logic [DUTY_W-1:0] share_a;
        logic [DUTY_W-1:0] share_b;
    } share_res_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_CALC,
        T_EMIT
    } top_state_t;

    typedef enum logic [2:0] {
        U_IDLE,
        U_SQ_A,
        U_SQ_B,
        U_MUL_B,
        U_DIV_B,
        U_MUL_A,
        U_DIV_A
    } unit_state_t;

endpackage

`default_nettype wire

FILE: rtl/ilfd_share_unit.sv
// ----------------------------------------------------------------------------
// ilfd_share_unit
// Computes floor(fs*b^2/(a^2+b^2)) and floor(fs*a^2/(a^2+b^2)) with one
// shared multiplier and one shared compare/subtract, restoring division.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfd_share_unit #(
    parameter int SAMPLE_W = 10
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [SAMPLE_W-1:0]         a_in,
    input  wire logic [SAMPLE_W-1:0]         b_in,
    input  wire logic [ilfd_pkg::DUTY_W-1:0] fs_in,
    output ilfd_pkg::share_res_t             res
);
    import ilfd_pkg::*;

    localparam int SQ_W   = 2 * SAMPLE_W;
    localparam int SUM_W  = SQ_W + 1;
    localparam int PW     = SQ_W + DUTY_W;
    localparam int PROD_W = SQ_W + SAMPLE_W;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DUTY_W - 1);

    unit_state_t         state_reg, state_next;
    logic [SAMPLE_W-1:0] a_reg, a_next;
    logic [SAMPLE_W-1:0] b_reg, b_next;
    logic [DUTY_W-1:0]   fs_reg, fs_next;
    logic [SQ_W-1:0]     sa_reg, sa_next;
    logic [SQ_W-1:0]     sb_reg, sb_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [PW-1:0]       rem_reg, rem_next;
    logic [DUTY_W-1:0]   quo_reg, quo_next;
    logic [DUTY_W-1:0]   share_b_reg, share_b_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    share_res_t          res_reg, res_next;

    // shared multiplier
    logic [SQ_W-1:0]     mul_x;
    logic [SAMPLE_W-1:0] mul_y;
    logic [PROD_W-1:0]   prod;

    // shared compare and subtract
    logic [PW-1:0]       trial;
    logic                ge;
    logic [PW-1:0]       rem_after;
    logic [DUTY_W-1:0]   quo_shift;
    logic [SUM_W-1:0]    sum_calc;

    always_comb begin
        unique case (state_reg)
            U_SQ_A: begin
                mul_x = SQ_W'(a_reg);
                mul_y = a_reg;
            end
            U_SQ_B: begin
                mul_x = SQ_W'(b_reg);
                mul_y = b_reg;
            end
            U_MUL_B: begin
                mul_x = sb_reg;
                mul_y = SAMPLE_W'(fs_reg);
            end
            default: begin
                mul_x = sa_reg;
                mul_y = SAMPLE_W'(fs_reg);
            end
        endcase
    end

    assign prod      = mul_x * mul_y;
    assign trial     = PW'(sum_reg) << step_reg;
    assign ge        = rem_reg >= trial;
    assign rem_after = ge ? rem_reg - trial : rem_reg;
    assign quo_shift = {quo_reg[DUTY_W-2:0], ge};
    assign sum_calc  = SUM_W'(sa_reg) + SUM_W'(prod[SQ_W-1:0]);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        fs_next      = fs_reg;
        sa_next      = sa_reg;
        sb_next      = sb_reg;
        sum_next     = sum_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        share_b_next = share_b_reg;
        step_next    = step_reg;
        res_next     = res_reg;
        res_next.done = 1'b0;
        unique case (state_reg)
            U_IDLE: begin
                if (start) begin
                    a_next     = a_in;
                    b_next     = b_in;
                    fs_next    = fs_in;
                    state_next = U_SQ_A;
                end
            end
            U_SQ_A: begin
                sa_next    = prod[SQ_W-1:0];
                state_next = U_SQ_B;
            end
            U_SQ_B: begin
                sb_next  = prod[SQ_W-1:0];
                sum_next = sum_calc;
                if (sum_calc == '0) begin
                    res_next.done = 1'b1;
                    res_next.zero = 1'b1;
                    state_next    = U_IDLE;
                end else begin
                    state_next = U_MUL_B;
                end
            end
            U_MUL_B: begin
                rem_next   = prod[PW-1:0];
                quo_next   = '0;
                step_next  = LAST_STEP;
                state_next = U_DIV_B;
            end
            U_DIV_B: begin
                rem_next  = rem_after;
                quo_next  = quo_shift;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    share_b_next = quo_shift;
                    state_next   = U_MUL_A;
                end
            end
            U_MUL_A: begin
                rem_next   = prod[PW-1:0];
                quo_next   = '0;
                step_next  = LAST_STEP;
                state_next = U_DIV_A;
            end
            U_DIV_A: begin
                rem_next  = rem_after;
                quo_next  = quo_shift;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    res_next.done    = 1'b1;
                    res_next.zero    = 1'b0;
                    res_next.share_a = quo_shift;
                    res_next.share_b = share_b_reg;
                    state_next       = U_IDLE;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    // state and result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= U_IDLE;
            res_reg   <= '0;
        end else begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        a_reg           <= a_next;
        b_reg           <= b_next;
        fs_reg          <= fs_next;
        sa_reg          <= sa_next;
        sb_reg          <= sb_next;
        sum_reg         <= sum_next;
        rem_reg         <= rem_next;
        quo_reg         <= quo_next;
        share_b_reg     <= share_b_next;
        step_reg        <= step_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire

FILE: rtl/inductive_line_follow_pwm_drive.sv
// ----------------------------------------------------------------------------
// inductive_line_follow_pwm_drive
// Line-following motor drive: sensor pair ratio sets wheel duties, tick beats
// advance the PWM counter, every beat returns the four pin levels.
// ----------------------------------------------------------------------------
// tick beat: the counter advances on accept and T_EMIT loads the pin levels
// sample beat: the share unit squares both codes, then runs the shared
//   multiplier and the 7-step restoring divide twice (skipped when both codes
//   are zero); no new beat is taken until T_EMIT has loaded the result
// one beat in flight; a finished result may wait in the output register
// reset (synchronous, aresetn low): counter and duties cleared, registers
//   at their reset values, no result pending
`default_nettype none

module inductive_line_follow_pwm_drive #(
    parameter int SAMPLE_BITS = 10
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire ilfd_pkg::in_beat_t             s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output ilfd_pkg::out_beat_t                 m_data,
    input  wire logic                           cfg_we,
    input  wire logic [ilfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ilfd_pkg::CFG_W-1:0]     cfg_wdata
);
    import ilfd_pkg::*;

    // codes wider than the input field keep all of its bits
    localparam int EFF_W = (SAMPLE_BITS < CODE_W) ? SAMPLE_BITS : CODE_W;

    top_state_t        state_reg, state_next;
    logic [1:0]        track_mode_reg;
    logic [DUTY_W-1:0] full_scale_reg;
    logic [DUTY_W-1:0] pwm_top_reg;
    logic [DUTY_W-1:0] cnt_reg, cnt_next;
    logic [DUTY_W:0]   duty_reg [4];
    logic [DUTY_W:0]   duty_next [4];
    logic              m_valid_reg, m_valid_next;
    out_beat_t         m_data_reg;
    out_beat_t         pins;
    logic              load_out;

    logic              in_beat;
    logic              start;
    logic              use_rear;
    logic              backward;
    logic [EFF_W-1:0]  code_a;
    logic [EFF_W-1:0]  code_b;
    logic [DUTY_W:0]   cnt_inc;
    share_res_t        res;

    assign s_ready  = (state_reg == T_IDLE);
    assign in_beat  = s_valid && s_ready;
    assign start    = in_beat && (s_data.opcode == OP_SAMPLE);
    assign use_rear = (track_mode_reg == MODE_BACK_REAR) || (track_mode_reg == MODE_FWD_REAR);
    assign backward = (track_mode_reg == MODE_BACK_REAR) || (track_mode_reg == MODE_BACK_FRONT);
    assign code_a   = use_rear ? s_data.rear_left[EFF_W-1:0]  : s_data.front_left[EFF_W-1:0];
    assign code_b   = use_rear ? s_data.rear_right[EFF_W-1:0] : s_data.front_right[EFF_W-1:0];
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;

    ilfd_share_unit #(
        .SAMPLE_W (EFF_W)
    ) u_share (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .a_in    (code_a),
        .b_in    (code_b),
        .fs_in   (full_scale_reg),
        .res     (res)
    );

    // pin compare against current counter and duties
    always_comb begin
        pins.left_a_pin  = !duty_reg[0][DUTY_W] && (cnt_reg <= duty_reg[0][DUTY_W-1:0]);
        pins.left_b_pin  = !duty_reg[1][DUTY_W] && (cnt_reg <= duty_reg[1][DUTY_W-1:0]);
        pins.right_a_pin = !duty_reg[2][DUTY_W] && (cnt_reg <= duty_reg[2][DUTY_W-1:0]);
        pins.right_b_pin = !duty_reg[3][DUTY_W] && (cnt_reg <= duty_reg[3][DUTY_W-1:0]);
    end

    // control sequencer
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        duty_next  = duty_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            T_IDLE: begin
                if (in_beat) begin
                    if (s_data.opcode == OP_TICK) begin
                        cnt_next   = (cnt_inc > {1'b0, pwm_top_reg}) ? '0
                                                                      : cnt_inc[DUTY_W-1:0];
                        state_next = T_EMIT;
                    end else begin
                        state_next = T_CALC;
                    end
                end
            end
            T_CALC: begin
                if (res.done) begin
                    if (res.zero) begin
                        duty_next[0] = DUTY_OFF;
                        duty_next[1] = DUTY_OFF;
                        duty_next[2] = DUTY_OFF;
                        duty_next[3] = DUTY_OFF;
                    end else if (backward) begin
                        duty_next[0] = {1'b0, res.share_b};
                        duty_next[1] = DUTY_OFF;
                        duty_next[2] = DUTY_OFF;
                        duty_next[3] = {1'b0, res.share_a};
                    end else begin
                        duty_next[0] = DUTY_OFF;
                        duty_next[1] = {1'b0, res.share_b};
                        duty_next[2] = {1'b0, res.share_a};
                        duty_next[3] = DUTY_OFF;
                    end
                    state_next = T_EMIT;
                end
            end
            T_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            cnt_reg     <= '0;
            duty_reg    <= '{default: '0};
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            duty_reg    <= duty_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= pins;
        end
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_mode_reg <= TRACK_MODE_RST;
            full_scale_reg <= FULL_SCALE_RST;
            pwm_top_reg    <= PWM_TOP_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_TRACK_MODE: track_mode_reg <= cfg_wdata[1:0];
                REG_FULL_SCALE: full_scale_reg <= cfg_wdata;
                REG_PWM_TOP:    pwm_top_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: rtl/ilfd_checker.sv
// ----------------------------------------------------------------------------
// ilfd_checker
// Port-level checks of the line follow drive, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ilfd_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           s_valid,
    input wire logic                           s_ready,
    input wire ilfd_pkg::in_beat_t             s_data,
    input wire logic                           m_valid,
    input wire logic                           m_ready,
    input wire ilfd_pkg::out_beat_t            m_data
);
    import ilfd_pkg::*;

    // a waiting result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed while stalled");

    // one beat in flight: accept closes the input side
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while a beat is in flight");

    // a new result only follows a busy cycle
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without an accepted beat");

    // a tick beat delivers once the output slot is free
    a_tick_delivers: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_data.opcode == OP_TICK) ##1 (!m_valid || m_ready)
        |=> m_valid && s_ready)
        else $error("tick beat result late");

endmodule

bind inductive_line_follow_pwm_drive ilfd_checker u_checker (.*);

`default_nettype wire
